// ===== src/srt_pkg.sv =====
// Shared types and constants for the slot registry table.
package srt_pkg;

	localparam int SRT_MAX_SLOTS = 32;
	localparam logic signed [15:0] HANDLER_NONE = -16'sd1;
	localparam logic [7:0] TYPE_FREE = 8'd0;

	typedef enum logic [1:0] {
		CMD_ENABLE  = 2'd0,
		CMD_DISABLE = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_FETCH   = 2'd3
	} srt_cmd_t;

	typedef struct packed {
		srt_cmd_t           command;
		logic [7:0]         type_id;
		logic signed [15:0] handler_index;
	} srt_req_t;

	typedef struct packed {
		logic               present;
		logic signed [15:0] handler_out;
		logic               table_full;
		logic [5:0]         active_count_out;
	} srt_rsp_t;

	typedef struct packed {
		logic               load;
		logic               scan;
		logic               wrap;
	} srt_ctl_t;

	typedef struct packed {
		logic               scan_done;
	} srt_stat_t;

	typedef struct packed {
		logic [7:0]         slot_type;
		logic signed [15:0] slot_handler;
	} srt_slot_t;

endpackage

// ===== src/srt_ctrl.sv =====
// Controller state machine that sequences load, slot scan and wrap-up of a request.
module srt_ctrl
	import srt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  srt_stat_t stat,
	output srt_ctl_t  ctl,
	output logic      busy,
	output logic      done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRAP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		ctl.load = start && (state_q == ST_IDLE);
		ctl.scan = (state_q == ST_SCAN);
		ctl.wrap = (state_q == ST_WRAP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (stat.scan_done) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	// The result strobe only follows the wrap-up cycle and never overlaps a busy request.
	a_done_after_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_WRAP))
		else $error("result strobe without wrap-up");
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while busy");

endmodule

// ===== src/srt_dpath.sv =====
// Datapath: slot memory, scan pointer, compare stage, active count and result register.
module srt_dpath
	import srt_pkg::*;
#(
	parameter int MAX_SLOTS = SRT_MAX_SLOTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  srt_ctl_t  ctl,
	input  srt_req_t  req,
	output srt_stat_t stat,
	output srt_rsp_t  rsp
);

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);

	srt_slot_t mem [MAX_SLOTS];

	srt_cmd_t           cmd_q;
	logic [7:0]         tid_q;
	logic signed [15:0] hnd_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               stop_q;
	logic               present_q;
	logic signed [15:0] hout_q;
	srt_rsp_t           res_q;

	srt_slot_t          rdata_s1;
	logic [CNT_W-1:0]   idx_s1;
	logic               vld_s1;

	logic               issue;
	logic               cmp_en;
	logic               hit;
	logic               hit_free;
	logic               is_last;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	srt_slot_t          wdata;
	logic               append;
	logic [CNT_W-1:0]   count_wrap;

	assign issue    = ctl.scan && !stop_q && (idx_q < count_q);
	assign cmp_en   = ctl.scan && vld_s1 && !stop_q;
	assign hit      = (rdata_s1.slot_type == tid_q);
	assign hit_free = (rdata_s1.slot_type == TYPE_FREE);
	assign is_last  = ((idx_s1 + CNT_W'(1)) == count_q);
	assign append   = ctl.wrap && (cmd_q == CMD_ENABLE) && !stop_q && (count_q < CNT_MAX);
	assign count_wrap = append ? (count_q + CNT_W'(1)) : count_q;

	assign stat.scan_done = stop_q || (!vld_s1 && (idx_q >= count_q));

	// One write port: a reused or cleared slot during the scan, or an append at wrap-up.
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1[IDX_W-1:0];
		wdata = '{slot_type: tid_q, slot_handler: hnd_q};
		if (cmp_en && (cmd_q == CMD_ENABLE) && hit_free) begin
			we = 1'b1;
		end else if (cmp_en && (cmd_q == CMD_DISABLE) && hit) begin
			we    = 1'b1;
			wdata = '{slot_type: TYPE_FREE, slot_handler: HANDLER_NONE};
		end else if (append) begin
			we    = 1'b1;
			waddr = count_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Reads are issued one slot per cycle; the compare stage works on each read in the cycle after it is issued.
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[idx_q[IDX_W-1:0]];
			idx_s1   <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1  <= 1'b0;
			stop_q  <= 1'b0;
		end else begin
			priority if (ctl.load) begin
				vld_s1 <= 1'b0;
				stop_q <= 1'b0;
			end else if (ctl.wrap) begin
				vld_s1  <= 1'b0;
				count_q <= count_wrap;
			end else begin
				vld_s1 <= issue;
				if (cmp_en) begin
					unique case (cmd_q)
						CMD_ENABLE: begin
							if (hit_free) begin
								stop_q <= 1'b1;
							end
						end
						CMD_DISABLE: begin
							// Only a match in the last active slot shrinks the count.
							if (hit && is_last) begin
								count_q <= count_q - CNT_W'(1);
								stop_q  <= 1'b1;
							end
						end
						CMD_QUERY, CMD_FETCH: begin
							if (hit) begin
								stop_q <= 1'b1;
							end
						end
						default: begin
							stop_q <= stop_q;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q     <= req.command;
			tid_q     <= req.type_id;
			hnd_q     <= req.handler_index;
			idx_q     <= '0;
			present_q <= 1'b0;
			hout_q    <= HANDLER_NONE;
		end else begin
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmp_en && hit && ((cmd_q == CMD_QUERY) || (cmd_q == CMD_FETCH))) begin
				present_q <= 1'b1;
				hout_q    <= rdata_s1.slot_handler;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wrap) begin
			res_q.present          <= present_q;
			res_q.handler_out      <= (cmd_q == CMD_FETCH) ? hout_q : HANDLER_NONE;
			res_q.table_full       <= (cmd_q == CMD_ENABLE) && !stop_q && !append;
			res_q.active_count_out <= 6'(count_wrap);
		end
	end

	assign rsp = res_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("active count beyond capacity");
	a_compare_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (idx_s1 < count_q))
		else $error("compare stage holds a slot outside the active range");

endmodule

// ===== src/slot_registry_table_top.sv =====
// Top level of the slot registry table: controller plus datapath.
//
//  channel   ports                 handshake
//  request   start, busy, req      taken at a clock edge with start high and busy low
//  result    done, rsp             done high for one cycle; rsp valid in that cycle
//
// With count active slots, a scan over every slot issues count reads, each compared in the stage
// behind, before wrap-up; an empty table ends the scan at once. Enable stops at the first
// free slot and query and fetch at the first hit, so a hit ends the scan early.
// The scan reads the slot memory (one read and one write port) one slot per cycle; busy stays high until done.
// Reset clears the active count and the controller; slot contents are not cleared.
// The receiver cannot stall; the next request is taken at the edge that ends the done cycle.
module slot_registry_table_top
	import srt_pkg::*;
#(
	parameter int MAX_SLOTS = SRT_MAX_SLOTS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  srt_req_t req,
	output logic     busy,
	output logic     done,
	output srt_rsp_t rsp
);

	srt_ctl_t  ctl;
	srt_stat_t stat;

	srt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	srt_dpath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the slot registry table: directed and random command streams.
module testbench;
	import srt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic     clk;
	logic     arst_n;
	logic     start;
	srt_req_t req;
	logic     busy;
	logic     done;
	srt_rsp_t rsp;

	slot_registry_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	// Shadow copy of the slot table that predicts the response to every accepted request.
	class registry_shadow;
		logic [7:0]         slot_id [SRT_MAX_SLOTS];
		logic signed [15:0] slot_hnd [SRT_MAX_SLOTS];
		int unsigned        occupancy;
		srt_rsp_t           expected_rsp[$];
		int                 errors;
		int                 cmd_seen [4];
		int                 full_seen;
		int unsigned        peak;

		function new();
			occupancy = 0;
			errors = 0;
			full_seen = 0;
			peak = 0;
			foreach (cmd_seen[k])
				cmd_seen[k] = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// Type held by the last active slot, so that a disable can shrink the count.
		function logic [7:0] tail_type();
			if (occupancy == 0)
				return 8'd1;
			return slot_id[occupancy - 1];
		endfunction

		function logic [7:0] held_type();
			if (occupancy == 0)
				return 8'd2;
			return slot_id[$urandom_range(occupancy - 1)];
		endfunction

		function void take_request(srt_req_t r);
			srt_rsp_t e;
			bit       hit;
			int       i;
			e.present = 1'b0;
			e.handler_out = HANDLER_NONE;
			e.table_full = 1'b0;
			case (r.command)
				CMD_ENABLE: begin
					hit = 0;
					for (i = 0; i < occupancy && !hit; i++) begin
						if (slot_id[i] == TYPE_FREE) begin
							slot_id[i] = r.type_id;
							slot_hnd[i] = r.handler_index;
							hit = 1;
						end
					end
					if (!hit) begin
						if (occupancy < SRT_MAX_SLOTS) begin
							slot_id[occupancy] = r.type_id;
							slot_hnd[occupancy] = r.handler_index;
							occupancy++;
						end else begin
							e.table_full = 1'b1;
						end
					end
				end
				CMD_DISABLE: begin
					for (i = 0; i < occupancy; i++) begin
						if (slot_id[i] == r.type_id) begin
							slot_id[i] = TYPE_FREE;
							slot_hnd[i] = HANDLER_NONE;
							// Only a hit on the last active slot shortens the table, by one.
							if (i + 1 == occupancy) begin
								occupancy--;
								break;
							end
						end
					end
				end
				default: begin
					for (i = 0; i < occupancy; i++) begin
						if (slot_id[i] == r.type_id) begin
							e.present = 1'b1;
							if (r.command == CMD_FETCH)
								e.handler_out = slot_hnd[i];
							break;
						end
					end
				end
			endcase
			e.active_count_out = occupancy[5:0];
			expected_rsp.push_back(e);
			cmd_seen[r.command]++;
			if (e.table_full)
				full_seen++;
			if (occupancy > peak)
				peak = occupancy;
		endfunction

		function void check_response(srt_rsp_t a);
			srt_rsp_t e;
			if (expected_rsp.size() == 0) begin
				$error("response with no request outstanding: %p", a);
				errors++;
				return;
			end
			e = expected_rsp.pop_front();
			if (a.present !== e.present) begin
				$error("present: expected %0b, actual %0b", e.present, a.present);
				errors++;
			end
			if (a.handler_out !== e.handler_out) begin
				$error("handler_out: expected %0d, actual %0d", e.handler_out, a.handler_out);
				errors++;
			end
			if (a.table_full !== e.table_full) begin
				$error("table_full: expected %0b, actual %0b", e.table_full, a.table_full);
				errors++;
			end
			if (a.active_count_out !== e.active_count_out) begin
				$error("active_count_out: expected %0d, actual %0d",
					e.active_count_out, a.active_count_out);
				errors++;
			end
		endfunction
	endclass

	registry_shadow shadow = new();

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				shadow.check_response(rsp);
			if (start && !busy)
				shadow.take_request(req);
		end
	end

	function automatic srt_req_t request_of(srt_cmd_t c, logic [7:0] id, logic signed [15:0] h);
		srt_req_t r;
		r.command = c;
		r.type_id = id;
		r.handler_index = h;
		return r;
	endfunction

	// Mostly a small pool of ids so that lookups hit, with free ids and the full range mixed in.
	function automatic logic [7:0] pick_type();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return TYPE_FREE;
		if (r < 78)
			return 8'($urandom_range(1, 10));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic signed [15:0] pick_handler();
		if ($urandom_range(9) == 0)
			return HANDLER_NONE;
		return 16'($urandom_range(32767));
	endfunction

	function automatic srt_req_t random_request(bit filling);
		int         r;
		srt_cmd_t   c;
		logic [7:0] id;
		r = $urandom_range(99);
		if (filling)
			c = r < 55 ? CMD_ENABLE : r < 65 ? CMD_DISABLE : r < 80 ? CMD_QUERY : CMD_FETCH;
		else
			c = r < 15 ? CMD_ENABLE : r < 55 ? CMD_DISABLE : r < 70 ? CMD_QUERY : CMD_FETCH;
		id = pick_type();
		if (c == CMD_DISABLE && $urandom_range(99) < 35)
			id = shadow.tail_type();
		else if ((c == CMD_QUERY || c == CMD_FETCH) && $urandom_range(99) < 45)
			id = shadow.held_type();
		return request_of(c, id, pick_handler());
	endfunction

	// Present one request, idling first with the given chance per cycle, and hold it until taken.
	task automatic send(srt_req_t r, int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (shadow.pending() > 0);
	endtask

	initial begin
		srt_req_t directed[$];
		int       idle_pct [4];
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_pct = '{0, 58, 24, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lookups on an empty table, then a short table with duplicates, holes and trims.
		directed.push_back(request_of(CMD_QUERY, 8'd0, 16'sd0));
		directed.push_back(request_of(CMD_FETCH, 8'd255, 16'sd0));
		directed.push_back(request_of(CMD_DISABLE, 8'd3, -16'sd1));
		directed.push_back(request_of(CMD_ENABLE, 8'd0, 16'sd0));
		directed.push_back(request_of(CMD_ENABLE, 8'd255, 16'sd32767));
		directed.push_back(request_of(CMD_ENABLE, 8'd7, HANDLER_NONE));
		directed.push_back(request_of(CMD_ENABLE, 8'd7, 16'sh5555));
		directed.push_back(request_of(CMD_ENABLE, 8'd170, 16'sh2AAA));
		directed.push_back(request_of(CMD_FETCH, 8'd255, 16'sd0));
		directed.push_back(request_of(CMD_FETCH, 8'd7, -16'sd1));
		directed.push_back(request_of(CMD_QUERY, 8'd0, 16'sd5));
		directed.push_back(request_of(CMD_FETCH, 8'd0, 16'sd0));
		directed.push_back(request_of(CMD_DISABLE, 8'd255, 16'sd0));
		directed.push_back(request_of(CMD_ENABLE, 8'd9, 16'sd1234));
		directed.push_back(request_of(CMD_FETCH, 8'd9, 16'sd0));
		directed.push_back(request_of(CMD_QUERY, 8'd255, 16'sd0));
		directed.push_back(request_of(CMD_DISABLE, 8'd170, 16'sd0));
		directed.push_back(request_of(CMD_DISABLE, 8'd7, 16'sd0));
		directed.push_back(request_of(CMD_FETCH, 8'd7, 16'sd0));
		directed.push_back(request_of(CMD_DISABLE, 8'd0, 16'sd0));
		directed.push_back(request_of(CMD_QUERY, 8'd0, 16'sd0));
		directed.push_back(request_of(CMD_FETCH, 8'd9, 16'sd0));
		directed.push_back(request_of(CMD_ENABLE, 8'd85, 16'sd0));
		foreach (directed[k])
			send(directed[k], 0);
		drain();

		// Each phase alternates stretches that fill the table with stretches that empty it.
		foreach (idle_pct[p]) begin
			for (int k = 0; k < 450; k++)
				send(random_request(((k / 80) % 2) == 0), idle_pct[p]);
			drain();
		end

		repeat (40) @(posedge clk);
		$display("Checked %0d requests: %0d enable, %0d disable, %0d query, %0d fetch.",
			shadow.cmd_seen[CMD_ENABLE] + shadow.cmd_seen[CMD_DISABLE] +
			shadow.cmd_seen[CMD_QUERY] + shadow.cmd_seen[CMD_FETCH],
			shadow.cmd_seen[CMD_ENABLE], shadow.cmd_seen[CMD_DISABLE],
			shadow.cmd_seen[CMD_QUERY], shadow.cmd_seen[CMD_FETCH]);
		$display("Enable hit a full table %0d times; peak occupancy was %0d of %0d slots.",
			shadow.full_seen, shadow.peak, SRT_MAX_SLOTS);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/srt_pkg.sv
src/srt_ctrl.sv
src/srt_dpath.sv
src/slot_registry_table_top.sv
dv/testbench.sv
